[rtl/lpi_pkg.sv]
`default_nettype none
package lpi_pkg;

	localparam int COORD_BITS = 11;

	localparam int LW  = COORD_BITS + 1;
	localparam int PW  = 2 * COORD_BITS;
	localparam int A2W = 2 * COORD_BITS + 1;
	localparam int MW  = 2 * LW;
	localparam int HWW = 2 * COORD_BITS + 2;
	localparam int HXW = LW + A2W;
	localparam int NB  = 3 * COORD_BITS + 1;
	localparam int DB  = 2 * COORD_BITS + 1;
	localparam int WW  = DB + NB;
	localparam int EXT = (NB > 32) ? NB : 33;

	localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] OUT_ONE = 32'sd1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t first_start_x;
		coord_t first_start_y;
		coord_t first_end_x;
		coord_t first_end_y;
		coord_t second_start_x;
		coord_t second_start_y;
		coord_t second_end_x;
		coord_t second_end_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] meet_x;
		logic signed [31:0] meet_y;
		logic               found;
		logic               clipped;
	} out_item_t;

	typedef struct packed {
		logic          zero;
		logic          neg_x;
		logic          neg_y;
		logic [NB-1:0] mag_x;
		logic [NB-1:0] mag_y;
		logic [DB-1:0] mag_w;
	} hp_t;

	typedef struct packed {
		logic          zero;
		logic          neg_x;
		logic          neg_y;
		logic [DB-1:0] dvs;
		logic [WW-1:0] wx;
		logic [WW-1:0] wy;
	} div_t;

endpackage
`default_nettype wire

[rtl/lpi_in_if.sv]
`default_nettype none
interface lpi_in_if;
	logic               valid;
	logic               ready;
	lpi_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/lpi_out_if.sv]
`default_nettype none
interface lpi_out_if;
	logic               valid;
	logic               ready;
	lpi_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/line_pair_intersection.sv]
`default_nettype none
// Intersects the infinite lines through two segments with unsigned pixel
// endpoints and returns the meeting point truncated toward zero, with found
// low and the point (1,1) when the lines are parallel or a segment is a single
// point, and clipped high when a coordinate saturates to the signed 32-bit
// range. One transaction is taken every cycle unless the output stalls;
// five stages form the lines and the homogeneous point, a divider pipeline
// resolves one quotient bit per stage for both coordinates, and a final stage
// saturates into the output register. Backpressure from the output stalls
// only the stages that hold data, so bubbles close up.
module line_pair_intersection (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lpi_in_if.sink     in_ch,
	lpi_out_if.source  out_ch
);

	logic               hp_vld, hp_rdy;
	lpi_pkg::hp_t       hp;
	logic               dv_vld, dv_rdy;
	lpi_pkg::div_t      dv;
	logic               vld_q;
	logic               en;
	lpi_pkg::out_item_t res_q;
	lpi_pkg::out_item_t res;
	logic               clip_x, clip_y;
	logic [31:0]        val_x, val_y;

	function automatic logic [32:0] saturate(
		input logic                neg,
		input logic [lpi_pkg::NB-1:0] q
	);
		logic [lpi_pkg::EXT-1:0] qe;
		logic [lpi_pkg::EXT-1:0] v;
		logic [32:0]             r;
		qe = lpi_pkg::EXT'(q);
		v  = neg ? (lpi_pkg::EXT'(0) - qe) : qe;
		if (!neg && qe > lpi_pkg::EXT'(33'h0_7FFF_FFFF)) begin
			r = {1'b1, lpi_pkg::OUT_MAX};
		end else if (neg && qe > lpi_pkg::EXT'(33'h0_8000_0000)) begin
			r = {1'b1, lpi_pkg::OUT_MIN};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	lpi_lines u_lines (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (in_ch.valid),
		.in_rdy  (in_ch.ready),
		.in_item (in_ch.data),
		.out_vld (hp_vld),
		.out_rdy (hp_rdy),
		.out_hp  (hp)
	);

	lpi_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (hp_vld),
		.in_rdy  (hp_rdy),
		.in_hp   (hp),
		.out_vld (dv_vld),
		.out_rdy (dv_rdy),
		.out_div (dv)
	);

	always_comb begin
		{clip_x, val_x} = saturate(dv.neg_x, dv.wx[lpi_pkg::NB-1:0]);
		{clip_y, val_y} = saturate(dv.neg_y, dv.wy[lpi_pkg::NB-1:0]);
		if (dv.zero) begin
			res.meet_x  = lpi_pkg::OUT_ONE;
			res.meet_y  = lpi_pkg::OUT_ONE;
			res.found   = 1'b0;
			res.clipped = 1'b0;
		end else begin
			res.meet_x  = $signed(val_x);
			res.meet_y  = $signed(val_y);
			res.found   = 1'b1;
			res.clipped = clip_x | clip_y;
		end
	end

	assign en     = ~vld_q | out_ch.ready;
	assign dv_rdy = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = vld_q;
	assign out_ch.data  = res_q;

endmodule
`default_nettype wire

[rtl/lpi_lines.sv]
`default_nettype none
module lpi_lines (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	output logic                   in_rdy,
	input  wire lpi_pkg::in_item_t in_item,
	output logic                   out_vld,
	input  wire logic              out_rdy,
	output lpi_pkg::hp_t           out_hp
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	logic signed [lpi_pkg::LW-1:0]  a0_s1, a1_s1, b0_s1, b1_s1;
	logic [lpi_pkg::PW-1:0]         pa0_s1, pa1_s1, pb0_s1, pb1_s1;

	logic signed [lpi_pkg::LW-1:0]  a0_s2, a1_s2, b0_s2, b1_s2;
	logic signed [lpi_pkg::A2W-1:0] a2_s2, b2_s2;
	logic signed [lpi_pkg::MW-1:0]  m0_s2, m1_s2;

	logic signed [lpi_pkg::HWW-1:0] hw_s3;
	logic signed [lpi_pkg::HXW-1:0] px0_s3, px1_s3, py0_s3, py1_s3;

	logic signed [lpi_pkg::HWW-1:0] hw_s4;
	logic signed [lpi_pkg::HXW-1:0] hx_s4, hy_s4;

	lpi_pkg::hp_t hp_s5;

	logic signed [lpi_pkg::HXW-1:0] abs_x, abs_y;
	logic signed [lpi_pkg::HWW-1:0] abs_w;

	assign en5    = ~vld_s5 | out_rdy;
	assign en4    = ~vld_s4 | en5;
	assign en3    = ~vld_s3 | en4;
	assign en2    = ~vld_s2 | en3;
	assign en1    = ~vld_s1 | en2;
	assign in_rdy = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_vld;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// line through (x0,y0,1) x (x1,y1,1) = (y0-y1, x1-x0, x0*y1-y0*x1)
	always_ff @(posedge clk) begin
		if (en1) begin
			a0_s1  <= $signed({1'b0, in_item.first_start_y}) - $signed({1'b0, in_item.first_end_y});
			a1_s1  <= $signed({1'b0, in_item.first_end_x}) - $signed({1'b0, in_item.first_start_x});
			b0_s1  <= $signed({1'b0, in_item.second_start_y})
			          - $signed({1'b0, in_item.second_end_y});
			b1_s1  <= $signed({1'b0, in_item.second_end_x})
			          - $signed({1'b0, in_item.second_start_x});
			pa0_s1 <= in_item.first_start_x * in_item.first_end_y;
			pa1_s1 <= in_item.first_start_y * in_item.first_end_x;
			pb0_s1 <= in_item.second_start_x * in_item.second_end_y;
			pb1_s1 <= in_item.second_start_y * in_item.second_end_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			a0_s2 <= a0_s1;
			a1_s2 <= a1_s1;
			b0_s2 <= b0_s1;
			b1_s2 <= b1_s1;
			a2_s2 <= $signed({1'b0, pa0_s1}) - $signed({1'b0, pa1_s1});
			b2_s2 <= $signed({1'b0, pb0_s1}) - $signed({1'b0, pb1_s1});
			m0_s2 <= a0_s1 * b1_s1;
			m1_s2 <= a1_s1 * b0_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			hw_s3  <= lpi_pkg::HWW'(m0_s2) - lpi_pkg::HWW'(m1_s2);
			px0_s3 <= a1_s2 * b2_s2;
			px1_s3 <= a2_s2 * b1_s2;
			py0_s3 <= a2_s2 * b0_s2;
			py1_s3 <= a0_s2 * b2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			hw_s4 <= hw_s3;
			hx_s4 <= px0_s3 - px1_s3;
			hy_s4 <= py0_s3 - py1_s3;
		end
	end

	always_comb begin
		abs_x = hx_s4[lpi_pkg::HXW-1] ? -hx_s4 : hx_s4;
		abs_y = hy_s4[lpi_pkg::HXW-1] ? -hy_s4 : hy_s4;
		abs_w = hw_s4[lpi_pkg::HWW-1] ? -hw_s4 : hw_s4;
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			hp_s5.zero  <= (hw_s4 == '0);
			hp_s5.neg_x <= hx_s4[lpi_pkg::HXW-1] ^ hw_s4[lpi_pkg::HWW-1];
			hp_s5.neg_y <= hy_s4[lpi_pkg::HXW-1] ^ hw_s4[lpi_pkg::HWW-1];
			hp_s5.mag_x <= abs_x[lpi_pkg::NB-1:0];
			hp_s5.mag_y <= abs_y[lpi_pkg::NB-1:0];
			hp_s5.mag_w <= abs_w[lpi_pkg::DB-1:0];
		end
	end

	assign out_vld = vld_s5;
	assign out_hp  = hp_s5;

endmodule
`default_nettype wire

[rtl/lpi_div_stage.sv]
`default_nettype none
module lpi_div_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	output logic               in_rdy,
	input  wire lpi_pkg::div_t in_div,
	output logic               out_vld,
	input  wire logic          out_rdy,
	output lpi_pkg::div_t      out_div
);

	logic          vld_s1;
	logic          en;
	lpi_pkg::div_t step_s1;
	lpi_pkg::div_t nxt;

	function automatic logic [lpi_pkg::WW-1:0] shift_sub(
		input logic [lpi_pkg::WW-1:0] w,
		input logic [lpi_pkg::DB-1:0] d
	);
		logic [lpi_pkg::WW:0]   s;
		logic [lpi_pkg::DB:0]   top;
		logic [lpi_pkg::DB:0]   dif;
		logic [lpi_pkg::WW-1:0] r;
		s   = {w, 1'b0};
		top = s[lpi_pkg::WW:lpi_pkg::NB];
		dif = top - {1'b0, d};
		if (top >= {1'b0, d}) begin
			r = {dif[lpi_pkg::DB-1:0], s[lpi_pkg::NB-1:1], 1'b1};
		end else begin
			r = {top[lpi_pkg::DB-1:0], s[lpi_pkg::NB-1:0]};
		end
		return r;
	endfunction

	always_comb begin
		nxt    = in_div;
		nxt.wx = shift_sub(in_div.wx, in_div.dvs);
		nxt.wy = shift_sub(in_div.wy, in_div.dvs);
	end

	assign en     = ~vld_s1 | out_rdy;
	assign in_rdy = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_div = step_s1;

endmodule
`default_nettype wire

[rtl/lpi_divider.sv]
`default_nettype none
module lpi_divider (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_vld,
	output logic              in_rdy,
	input  wire lpi_pkg::hp_t in_hp,
	output logic              out_vld,
	input  wire logic         out_rdy,
	output lpi_pkg::div_t     out_div
);

	logic          vld [lpi_pkg::NB+1];
	logic          rdy [lpi_pkg::NB+1];
	lpi_pkg::div_t dat [lpi_pkg::NB+1];

	always_comb begin
		dat[0].zero  = in_hp.zero;
		dat[0].neg_x = in_hp.neg_x;
		dat[0].neg_y = in_hp.neg_y;
		dat[0].dvs   = in_hp.mag_w;
		dat[0].wx    = lpi_pkg::WW'(in_hp.mag_x);
		dat[0].wy    = lpi_pkg::WW'(in_hp.mag_y);
	end

	assign vld[0] = in_vld;
	assign in_rdy = rdy[0];

	for (genvar k = 0; k < lpi_pkg::NB; k++) begin : g_step
		lpi_div_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vld[k]),
			.in_rdy  (rdy[k]),
			.in_div  (dat[k]),
			.out_vld (vld[k+1]),
			.out_rdy (rdy[k+1]),
			.out_div (dat[k+1])
		);
	end

	assign rdy[lpi_pkg::NB] = out_rdy;
	assign out_vld          = vld[lpi_pkg::NB];
	assign out_div          = dat[lpi_pkg::NB];

endmodule
`default_nettype wire
